// ===== rtl/lnt_pkg.sv =====
package lnt_pkg;

  localparam int MAX_SAMPLES_DEF = 16;

  // divider operand widths
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 17;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_TRAIN    = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;

  localparam logic [2:0] REG_INIT_W1  = 3'd0;
  localparam logic [2:0] REG_INIT_W2  = 3'd1;
  localparam logic [2:0] REG_INIT_B   = 3'd2;
  localparam logic [2:0] REG_LEARN    = 3'd3;
  localparam logic [2:0] REG_NUDGE    = 3'd4;
  localparam logic [2:0] REG_ITER     = 3'd5;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] HALF_Q16  = 17'd32768;
  localparam logic [16:0] SIG_TOP   = 17'd65514;
  localparam logic [31:0] SIG_CLAMP = 32'd524288;

  localparam logic [16:0] LEARN_RST = 17'd6554;
  localparam logic [16:0] NUDGE_RST = 17'd6554;
  localparam logic [23:0] ITER_RST  = 24'd320000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [16:0]        target_value;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] result_weight_one;
    logic signed [31:0] result_weight_two;
    logic signed [31:0] result_bias;
    logic [16:0]        result_cost;
    logic               class_bit;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic [16:0]        target;
  } sample_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ITER, ST_EVAL, ST_RD, ST_MUL, ST_SUM, ST_SIG, ST_ERR, ST_ACC,
    ST_CDIV, ST_CWAIT, ST_CNEXT, ST_SDIV, ST_SWAIT, ST_UMUL, ST_UAPPLY, ST_RESULT
  } state_t;

  // sigmoid at steps of 0.5, Q16
  function automatic logic [16:0] sig_point(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd32768;
      5'd1:  r = 17'd40793;
      5'd2:  r = 17'd47911;
      5'd3:  r = 17'd53581;
      5'd4:  r = 17'd57724;
      5'd5:  r = 17'd60565;
      5'd6:  r = 17'd62428;
      5'd7:  r = 17'd63615;
      5'd8:  r = 17'd64357;
      5'd9:  r = 17'd64816;
      5'd10: r = 17'd65097;
      5'd11: r = 17'd65269;
      5'd12: r = 17'd65374;
      5'd13: r = 17'd65437;
      5'd14: r = 17'd65476;
      5'd15: r = 17'd65500;
      default: r = 17'd65514;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/lnt_sample_mem.sv =====
module lnt_sample_mem
  import lnt_pkg::*;
#(
  parameter int DEPTH = MAX_SAMPLES_DEF,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sample_t       wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output sample_t       rd_data
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lnt_divider.sv =====
module lnt_divider
  import lnt_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNW = $clog2(NW);

  logic           busy;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  dvs;
  logic [CNW-1:0] cnt;
  logic [DW:0]    trial;
  logic           ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quot[NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        quot <= num;
      end else if (busy) begin
        rem  <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        quot <= {quot[NW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/logistic_neuron_trainer.sv =====
// channel | dir | handshake            | payload
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (register write)
// in      | in  | in_valid/in_ready    | in_data  (in_item_t)
// out     | out | out_valid/out_ready  | out_data (out_item_t)
//
// load: the sample is written while idle. classify: the inputs pass through the
// neuron datapath states MUL, SUM, SIG and ERR. train: iteration_total iterations,
// each with four cost passes and three parameter updates; each cost pass walks
// the sample memory entry by entry (an empty store skips the walk and the mean),
// and every division (cost mean, three slopes) holds the shared radix-2 divider.
// rst is synchronous and returns the registers to their reset values; the
// sample memory is not cleared, only entries below the sample count are read.
// in_ready is high only when idle; a finished result waits in the output
// register while the next item is taken.
module logistic_neuron_trainer
  import lnt_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SW = 20 + CW;

  state_t state, state_next;

  // configuration registers
  logic signed [31:0] init_w1, init_w2, init_b;
  logic [16:0]        learn_rate, nudge_step;
  logic [23:0]        iter_total;

  // model state
  logic [CW-1:0]      sample_count;
  logic signed [31:0] w1, w2, bias;
  logic [16:0]        last_cost;

  // sequencing
  logic [23:0]        iter;
  logic [1:0]         var_sel;   // which parameter is nudged in this cost pass
  logic [1:0]         pi;        // parameter being updated
  logic [CW-1:0]      idx;
  logic               use_in;

  // datapath registers
  logic signed [31:0] cx1, cx2;
  logic signed [63:0] p1, p2;
  logic signed [31:0] z;
  logic [16:0]        sig_base;
  logic [27:0]        sig_prod;
  logic               sig_neg, sig_top;
  logic [35:0]        dd;
  logic [SW-1:0]      sum;
  logic [16:0]        cost [4];
  logic               slope_neg;
  logic signed [34:0] slope;
  logic signed [52:0] upd_prod;
  logic               res_class;

  // memory and divider hookup
  sample_t            rd_data;
  sample_t            wr_sample;
  logic               mem_wr, mem_rd;
  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_num, div_quot;
  logic [DIV_DW-1:0]  div_den;

  logic               in_xfer;
  logic               sample_full;

  // combinational helpers
  logic [16:0]        eps;
  logic signed [47:0] eps_ext;
  logic signed [31:0] ew1, ew2, eb;
  logic signed [31:0] xa, xb;
  logic signed [48:0] zsum;
  logic signed [31:0] z_sat;
  logic [31:0]        za, zc;
  logic [4:0]         sidx;
  logic [14:0]        frac;
  logic [16:0]        sig_next, sig_diff;
  logic [16:0]        s_val, y_val;
  logic signed [17:0] d_err;
  logic signed [35:0] d_sq;
  logic signed [17:0] cdiff;
  logic [16:0]        cmag;
  logic signed [31:0] cur_param, new_param;
  logic [16:0]        cost_q;

  assign cfg_ready   = 1'b1;
  assign in_xfer     = in_valid && in_ready;
  assign sample_full = sample_count == CW'(MAX_SAMPLES);

  // zero nudge acts as one LSB
  assign eps     = (nudge_step == '0) ? 17'd1 : nudge_step;
  assign eps_ext = $signed({31'd0, eps});

  // nudged parameter set for the current cost pass
  assign ew1 = (var_sel == 2'd1) ? sat32(48'(w1) + eps_ext) : w1;
  assign ew2 = (var_sel == 2'd2) ? sat32(48'(w2) + eps_ext) : w2;
  assign eb  = (var_sel == 2'd3) ? sat32(48'(bias) + eps_ext) : bias;

  assign xa = use_in ? cx1 : rd_data.first;
  assign xb = use_in ? cx2 : rd_data.second;

  // neuron sum with floored shifts; two full-scale products need the extra bit
  assign zsum  = 49'(p1 >>> 16) + 49'(p2 >>> 16) + 49'(eb);
  assign z_sat = (zsum > 49'sd2147483647) ? 32'sh7fffffff :
                 (zsum < -49'sd2147483648) ? 32'sh80000000 : zsum[31:0];

  // sigmoid table index and interpolation fraction
  assign za       = z[31] ? 32'(-z) : 32'(z);
  assign zc       = (za > SIG_CLAMP) ? SIG_CLAMP : za;
  assign sidx     = zc[19:15];
  assign frac     = zc[14:0];
  assign sig_next = sig_point(5'(sidx + 5'd1));
  assign sig_diff = sig_next - sig_point(sidx);

  assign s_val = sig_top ? SIG_TOP : 17'(sig_base + 17'(sig_prod >> 15));
  assign y_val = sig_neg ? 17'(ONE_Q16 - s_val) : s_val;
  assign d_err = $signed({1'b0, y_val}) - $signed({1'b0, rd_data.target});
  assign d_sq  = 36'(d_err) * 36'(d_err);

  // slope numerator for the parameter under update
  assign cdiff = $signed({1'b0, cost[2'(pi + 2'd1)]}) - $signed({1'b0, cost[0]});
  assign cmag  = cdiff[17] ? 17'(-cdiff) : cdiff[16:0];

  always_comb begin
    case (pi)
      2'd0:    cur_param = w1;
      2'd1:    cur_param = w2;
      default: cur_param = bias;
    endcase
  end
  assign new_param = sat32(48'(cur_param) - 48'(upd_prod >>> 16));

  assign cost_q = (div_quot > DIV_NW'(ONE_Q16)) ? ONE_Q16 : div_quot[16:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.mode)
            MODE_TRAIN:    state_next = ST_ITER;
            MODE_CLASSIFY: state_next = ST_MUL;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_ITER:   state_next = (iter == iter_total) ? ST_RESULT : ST_EVAL;
      ST_EVAL:   state_next = (sample_count == '0) ? ST_CNEXT : ST_RD;
      ST_RD:     state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_SIG;
      ST_SIG:    state_next = ST_ERR;
      ST_ERR:    state_next = use_in ? ST_RESULT : ST_ACC;
      ST_ACC:    state_next = (CW'(idx + 1'b1) == sample_count) ? ST_CDIV : ST_RD;
      ST_CDIV:   state_next = ST_CWAIT;
      ST_CWAIT:  state_next = div_done ? ST_CNEXT : ST_CWAIT;
      ST_CNEXT:  state_next = (var_sel == 2'd3) ? ST_SDIV : ST_EVAL;
      ST_SDIV:   state_next = ST_SWAIT;
      ST_SWAIT:  state_next = div_done ? ST_UMUL : ST_SWAIT;
      ST_UMUL:   state_next = ST_UAPPLY;
      ST_UAPPLY: state_next = (pi == 2'd2) ? ST_ITER : ST_SDIV;
      ST_RESULT: state_next = (!out_valid || out_ready) ? ST_IDLE : ST_RESULT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_rd    = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RD:   mem_rd = 1'b1;
      ST_CDIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sum);
        div_den   = DIV_DW'(sample_count);
      end
      ST_SDIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({cmag, 16'd0});
        div_den   = eps;
      end
      default: ;
    endcase
  end

  assign mem_wr = in_xfer && (in_data.mode == MODE_LOAD) && !sample_full;

  assign wr_sample.first  = in_data.first_value;
  assign wr_sample.second = in_data.second_value;
  assign wr_sample.target = in_data.target_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_w1    <= '0;
      init_w2    <= '0;
      init_b     <= '0;
      learn_rate <= LEARN_RST;
      nudge_step <= NUDGE_RST;
      iter_total <= ITER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INIT_W1: init_w1    <= cfg_data;
        REG_INIT_W2: init_w2    <= cfg_data;
        REG_INIT_B:  init_b     <= cfg_data;
        REG_LEARN:   learn_rate <= cfg_data[16:0];
        REG_NUDGE:   nudge_step <= cfg_data[16:0];
        REG_ITER:    iter_total <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // model state and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      w1           <= '0;
      w2           <= '0;
      bias         <= '0;
      last_cost    <= '0;
      use_in       <= 1'b0;
      var_sel      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_data.mode)
              MODE_LOAD: begin
                if (!sample_full) sample_count <= sample_count + 1'b1;
              end
              MODE_TRAIN: begin
                w1        <= init_w1;
                w2        <= init_w2;
                bias      <= init_b;
                last_cost <= '0;
                iter      <= '0;
                use_in    <= 1'b0;
              end
              MODE_CLASSIFY: begin
                cx1     <= in_data.first_value;
                cx2     <= in_data.second_value;
                use_in  <= 1'b1;
                var_sel <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_ITER: var_sel <= '0;
        ST_EVAL: begin
          idx <= '0;
          sum <= '0;
          if (sample_count == '0) cost[var_sel] <= '0;
        end
        ST_ACC: begin
          sum <= sum + SW'(dd[35:16]);
          idx <= idx + 1'b1;
        end
        ST_CWAIT: begin
          if (div_done) cost[var_sel] <= cost_q;
        end
        ST_CNEXT: begin
          var_sel <= var_sel + 1'b1;
          pi      <= '0;
        end
        ST_SDIV: slope_neg <= cdiff[17];
        ST_SWAIT: begin
          if (div_done) begin
            slope <= slope_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
          end
        end
        ST_UAPPLY: begin
          case (pi)
            2'd0:    w1   <= new_param;
            2'd1:    w2   <= new_param;
            default: bias <= new_param;
          endcase
          pi <= pi + 1'b1;
          if (pi == 2'd2) begin
            last_cost <= cost[0];
            iter      <= iter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // neuron and sigmoid datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL: begin
        p1 <= xa * ew1;
        p2 <= xb * ew2;
      end
      ST_SUM: z <= z_sat;
      ST_SIG: begin
        sig_base <= sig_point(sidx);
        sig_prod <= sig_diff[12:0] * frac;
        sig_neg  <= z[31];
        sig_top  <= sidx >= 5'd16;
      end
      ST_ERR: begin
        dd        <= d_sq;
        res_class <= y_val >= HALF_Q16;
      end
      ST_UMUL: upd_prod <= $signed({1'b0, learn_rate}) * slope;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!out_valid || out_ready)) begin
      out_data.result_kind       <= use_in;
      out_data.result_weight_one <= use_in ? '0 : w1;
      out_data.result_weight_two <= use_in ? '0 : w2;
      out_data.result_bias       <= use_in ? '0 : bias;
      out_data.result_cost       <= use_in ? '0 : last_cost;
      out_data.class_bit         <= use_in ? res_class : 1'b0;
    end
  end

  lnt_sample_mem #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (sample_count[AW-1:0]),
    .wr_data (wr_sample),
    .rd_en   (mem_rd),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  lnt_divider #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule
